// ----- rtl/got_pkg.sv -----
`default_nettype none
package got_pkg;

	localparam int RATE_W  = 28;
	localparam int BIAS_W  = 44;
	localparam int FRAC_SH = 16;
	localparam int GAIN_SH = 8;
	localparam int GAIN_W  = 24;
	localparam int COUNT_W = 20;
	localparam int THR_W   = 27;
	localparam int CFG_W   = 27;
	localparam int IDX_W   = 2;
	localparam int TDATA_W = 88;

	localparam logic [GAIN_W-1:0]  GAIN_RST    = 24'd21082;
	localparam logic [COUNT_W-1:0] TIMEOUT_RST = 20'd500;
	localparam logic [THR_W-1:0]   THR_RST     = 27'd196608;

	typedef enum logic [IDX_W-1:0] {
		REG_FILTER_GAIN      = 2'd0,
		REG_STILL_TIMEOUT    = 2'd1,
		REG_MOTION_THRESHOLD = 2'd2
	} got_reg_e_t;

	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic [THR_W-1:0]  threshold;
		logic              track;
	} got_axis_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/got_axis.sv -----
`default_nettype none
module got_axis (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [got_pkg::RATE_W-1:0]   rate,
	input  got_pkg::got_axis_ctl_t              ctl,
	output logic signed [got_pkg::RATE_W-1:0]   fixed,
	output logic                                moving
);
	import got_pkg::*;

	logic signed [BIAS_W-1:0]            bias_q;
	logic signed [BIAS_W:0]              diff;
	logic signed [BIAS_W+1:0]            diff_rnd;
	logic signed [BIAS_W+1-FRAC_SH:0]    shifted;
	logic signed [RATE_W:0]              fixed_ext;
	logic signed [RATE_W:0]              mag_ext;
	logic signed [RATE_W+GAIN_W:0]       prod;
	logic signed [RATE_W+GAIN_W+1:0]     prod_rnd;
	logic signed [RATE_W+GAIN_W+1-GAIN_SH:0] inc;
	logic signed [RATE_W+GAIN_W+2-GAIN_SH:0] sum;
	logic signed [BIAS_W-1:0]            bias_next;

	assign diff = $signed({rate[RATE_W-1], rate, {FRAC_SH{1'b0}}})
		- $signed({bias_q[BIAS_W-1], bias_q});
	assign diff_rnd = $signed({diff[BIAS_W], diff})
		+ $signed({{(BIAS_W+2-FRAC_SH){1'b0}}, 1'b1, {(FRAC_SH-1){1'b0}}});
	assign shifted = diff_rnd[BIAS_W+1:FRAC_SH];

	always_comb begin
		if (shifted[BIAS_W+1-FRAC_SH:RATE_W-1] == '0
				|| shifted[BIAS_W+1-FRAC_SH:RATE_W-1] == '1) begin
			fixed = shifted[RATE_W-1:0];
		end else if (shifted[BIAS_W+1-FRAC_SH]) begin
			fixed = {1'b1, {(RATE_W-1){1'b0}}};
		end else begin
			fixed = {1'b0, {(RATE_W-1){1'b1}}};
		end
	end

	assign fixed_ext = {fixed[RATE_W-1], fixed};
	assign mag_ext = fixed[RATE_W-1] ? -fixed_ext : fixed_ext;
	assign moving = mag_ext[RATE_W-1:0] > {1'b0, ctl.threshold};

	assign prod = $signed({{(GAIN_W+1){fixed[RATE_W-1]}}, fixed})
		* $signed({{(RATE_W+1){1'b0}}, ctl.gain});
	assign prod_rnd = $signed({prod[RATE_W+GAIN_W], prod})
		+ $signed({{(RATE_W+GAIN_W+2-GAIN_SH){1'b0}}, 1'b1, {(GAIN_SH-1){1'b0}}});
	assign inc = prod_rnd[RATE_W+GAIN_W+1:GAIN_SH];
	assign sum = $signed({inc[RATE_W+GAIN_W+1-GAIN_SH], inc})
		+ $signed({{(RATE_W+GAIN_W+3-GAIN_SH-BIAS_W){bias_q[BIAS_W-1]}}, bias_q});

	always_comb begin
		if (sum[RATE_W+GAIN_W+2-GAIN_SH:BIAS_W-1] == '0
				|| sum[RATE_W+GAIN_W+2-GAIN_SH:BIAS_W-1] == '1) begin
			bias_next = sum[BIAS_W-1:0];
		end else if (sum[RATE_W+GAIN_W+2-GAIN_SH]) begin
			bias_next = {1'b1, {(BIAS_W-1){1'b0}}};
		end else begin
			bias_next = {1'b0, {(BIAS_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
		end else if (ctl.track) begin
			bias_q <= bias_next;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/gyro_offset_tracker_unit.sv -----
`default_nettype none
// Gyroscope offset tracker.
// Slave stream s_*: one three-axis rate sample per transaction, signed Q16 deg/s.
// Master stream m_*: the offset-corrected sample, rounded and saturated to 28 bits.
// Configuration: cfg_wr_en/cfg_index/cfg_data write filter_gain (0), still_timeout (1)
// and motion_threshold (2); other indexes are ignored. Write only while idle.
// An accepted sample passes through the input register and the result register to m_tdata.
// Throughput: one sample per cycle while m_tready is high. Each sample is corrected
// with the offsets left by the previous sample, so subtract, saturate, gain multiply
// and offset add are all combinational between the input and result registers.
// When m_tready is low the result register holds, the input register fills, and
// s_tready drops; nothing is lost or repeated.
// Reset clears the offsets and the stationary count and loads the default gain,
// timeout and threshold; both stream registers come up empty.
module gyro_offset_tracker_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [got_pkg::TDATA_W-1:0]   s_tdata,  // rate_x, rate_y, rate_z, zero pad
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [got_pkg::TDATA_W-1:0]   m_tdata,  // fixed_x, fixed_y, fixed_z, zero pad
	input  logic                          cfg_wr_en,
	input  logic [got_pkg::IDX_W-1:0]     cfg_index,
	input  logic [got_pkg::CFG_W-1:0]     cfg_data
);
	import got_pkg::*;

	logic [GAIN_W-1:0]  gain_q;
	logic [COUNT_W-1:0] timeout_q;
	logic [THR_W-1:0]   thr_q;
	logic [COUNT_W-1:0] still_count_q;

	logic                     valid_s1;
	logic signed [RATE_W-1:0] rate_x_s1, rate_y_s1, rate_z_s1;
	logic                     out_valid_q;
	logic signed [RATE_W-1:0] fixed_x_q, fixed_y_q, fixed_z_q;

	logic                     advance;
	logic                     any_moving;
	logic                     track;
	logic                     mov_x, mov_y, mov_z;
	logic signed [RATE_W-1:0] fix_x, fix_y, fix_z;
	got_axis_ctl_t            axis_ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q    <= GAIN_RST;
			timeout_q <= TIMEOUT_RST;
			thr_q     <= THR_RST;
		end else if (cfg_wr_en) begin
			unique case (got_reg_e_t'(cfg_index))
				REG_FILTER_GAIN:      gain_q    <= cfg_data[GAIN_W-1:0];
				REG_STILL_TIMEOUT:    timeout_q <= cfg_data[COUNT_W-1:0];
				REG_MOTION_THRESHOLD: thr_q     <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			rate_x_s1 <= s_tdata[RATE_W-1:0];
			rate_y_s1 <= s_tdata[2*RATE_W-1:RATE_W];
			rate_z_s1 <= s_tdata[3*RATE_W-1:2*RATE_W];
		end
	end

	assign any_moving = mov_x || mov_y || mov_z;
	assign track = advance && !any_moving && (still_count_q >= timeout_q);

	assign axis_ctl.gain      = gain_q;
	assign axis_ctl.threshold = thr_q;
	assign axis_ctl.track     = track;

	got_axis u_axis_x (
		.clk(clk), .arst_n(arst_n), .rate(rate_x_s1), .ctl(axis_ctl),
		.fixed(fix_x), .moving(mov_x)
	);
	got_axis u_axis_y (
		.clk(clk), .arst_n(arst_n), .rate(rate_y_s1), .ctl(axis_ctl),
		.fixed(fix_y), .moving(mov_y)
	);
	got_axis u_axis_z (
		.clk(clk), .arst_n(arst_n), .rate(rate_z_s1), .ctl(axis_ctl),
		.fixed(fix_z), .moving(mov_z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			still_count_q <= '0;
		end else if (advance) begin
			if (any_moving) begin
				still_count_q <= '0;
			end else if (still_count_q < timeout_q) begin
				still_count_q <= still_count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fixed_x_q <= fix_x;
			fixed_y_q <= fix_y;
			fixed_z_q <= fix_z;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TDATA_W-3*RATE_W){1'b0}}, fixed_z_q, fixed_y_q, fixed_x_q};

	a_count_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(still_count_q))
		else $error("stationary count changed without a transaction");

	a_motion_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && any_moving |=> still_count_q == '0)
		else $error("stationary count not cleared on motion");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("result register not loaded");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> !s_tready)
		else $error("input accepted over a held sample");

endmodule
`default_nettype wire

// ----- tb/tb_gyro_offset_tracker_unit.sv -----
module tb_gyro_offset_tracker_unit;
	import got_pkg::*;

	typedef logic [2:0][RATE_W-1:0] axes_t;

	typedef enum int {
		PICK_STILL,
		PICK_SPIKE,
		PICK_WILD
	} pick_t;

	localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

	localparam longint RATE_HI   = (longint'(1) <<< (RATE_W - 1)) - 1;
	localparam longint RATE_LO   = -(longint'(1) <<< (RATE_W - 1));
	localparam longint OFFS_HI   = (longint'(1) <<< (BIAS_W - 1)) - 1;
	localparam longint OFFS_LO   = -(longint'(1) <<< (BIAS_W - 1));
	localparam longint GAIN_MASK = (longint'(1) <<< GAIN_W) - 1;
	localparam longint CNT_MASK  = (longint'(1) <<< COUNT_W) - 1;
	localparam longint THR_MASK  = (longint'(1) <<< THR_W) - 1;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic                 cfg_wr_en = 1'b0;
	logic [IDX_W-1:0]     cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	gyro_offset_tracker_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	longint cfg_gain;
	longint cfg_timeout;
	longint cfg_thresh;
	longint still_run;
	longint axis_offset [3];

	axes_t  sample_fifo [$];
	axes_t  corrected_q [$];
	axes_t  want_res;

	string  axis_name [3] = '{"fixed_x", "fixed_y", "fixed_z"};

	int     pushed_count  = 0;
	int     rx_count      = 0;
	int     err_count     = 0;
	int     update_count  = 0;
	int     setting_count = 0;
	int     gap_left;
	int     hold_left;
	int     pause_len;
	bit     calm          = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint correct_axis(logic [RATE_W-1:0] raw, longint offs);
		longint d;
		d = longint'($signed(raw)) * 65536 - offs;
		return clip((d + 32768) >>> FRAC_SH, RATE_LO, RATE_HI);
	endfunction

	function automatic axes_t compensate(axes_t raw);
		axes_t  res;
		longint fx [3];
		longint mag;
		bit     moving;
		moving = 1'b0;
		for (int i = 0; i < 3; i++) begin
			fx[i] = correct_axis(raw[i], axis_offset[i]);
			mag = (fx[i] < 0) ? -fx[i] : fx[i];
			if (mag > cfg_thresh)
				moving = 1'b1;
			res[i] = fx[i][RATE_W-1:0];
		end
		if (moving) begin
			still_run = 0;
		end else if (still_run < cfg_timeout) begin
			still_run = (still_run + 1) & CNT_MASK;
		end else begin
			for (int i = 0; i < 3; i++)
				axis_offset[i] = clip(axis_offset[i] +
					((fx[i] * cfg_gain + 128) >>> GAIN_SH), OFFS_LO, OFFS_HI);
			update_count++;
		end
		return res;
	endfunction

	function automatic void send(longint x, longint y, longint z);
		axes_t a;
		a[0] = x[RATE_W-1:0];
		a[1] = y[RATE_W-1:0];
		a[2] = z[RATE_W-1:0];
		sample_fifo.push_back(a);
		pushed_count++;
	endfunction

	function automatic longint near_offset(int axis);
		longint span;
		longint v;
		span = (cfg_thresh > (longint'(1) <<< 26)) ? (longint'(1) <<< 26) : cfg_thresh;
		v = (axis_offset[axis] >>> FRAC_SH) - span - 4 +
			longint'($urandom_range(0, int'(2 * span + 8)));
		return clip(v, RATE_LO, RATE_HI);
	endfunction

	function automatic void send_random();
		longint v [3];
		longint mag;
		int     pick_roll;
		int     ax;
		pick_t  pick;
		pick_roll = $urandom_range(0, 9);
		pick = (pick_roll < 7) ? PICK_STILL : ((pick_roll < 8) ? PICK_SPIKE : PICK_WILD);
		for (int i = 0; i < 3; i++)
			v[i] = near_offset(i);
		case (pick)
			PICK_SPIKE: begin
				ax = $urandom_range(0, 2);
				mag = cfg_thresh + 1 + longint'($urandom_range(0, 1000));
				if ($urandom_range(0, 1))
					mag = -mag;
				v[ax] = clip((axis_offset[ax] >>> FRAC_SH) + mag, RATE_LO, RATE_HI);
			end
			PICK_WILD: begin
				for (int i = 0; i < 3; i++)
					v[i] = longint'($urandom);
			end
			default: ;
		endcase
		send(v[0], v[1], v[2]);
	endfunction

	task automatic drain();
		do @(posedge clk); while (rx_count != pushed_count);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, longint value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_FILTER_GAIN:      cfg_gain    = value[CFG_W-1:0] & GAIN_MASK;
			REG_STILL_TIMEOUT:    cfg_timeout = value[CFG_W-1:0] & CNT_MASK;
			REG_MOTION_THRESHOLD: cfg_thresh  = value[CFG_W-1:0] & THR_MASK;
			default: ;
		endcase
	endtask

	task automatic setup(longint gain, longint timeout, longint thresh);
		write_reg(REG_FILTER_GAIN, gain);
		write_reg(REG_STILL_TIMEOUT, timeout);
		write_reg(REG_MOTION_THRESHOLD, thresh);
		setting_count++;
	endtask

	task automatic run_random(int n);
		for (int i = 0; i < n; i++)
			send_random();
		drain();
	endtask

	// transaction source: predict on acceptance, then load the next sample after its gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready)
				corrected_q.push_back(compensate(s_tdata[3*RATE_W-1:0]));
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (sample_fifo.size() != 0) begin
					s_tdata  <= {{(TDATA_W - 3*RATE_W){1'b0}}, sample_fifo.pop_front()};
					s_tvalid <= 1'b1;
					gap_left <= calm ? 0 : $urandom_range(0, 4);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result sink: check each transaction, then hold off for a drawn pause or, now and then, a long stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (corrected_q.size() == 0) begin
					$error("unexpected result: tdata expected none, got %h", m_tdata);
					err_count++;
				end else begin
					want_res = corrected_q.pop_front();
					for (int i = 0; i < 3; i++)
						if (m_tdata[i*RATE_W +: RATE_W] !== want_res[i]) begin
							$error("%s: expected %0d, got %0d", axis_name[i],
								$signed(want_res[i]), $signed(m_tdata[i*RATE_W +: RATE_W]));
							err_count++;
						end
					if (m_tdata[TDATA_W-1:3*RATE_W] !== '0) begin
						$error("pad: expected 0, got %h", m_tdata[TDATA_W-1:3*RATE_W]);
						err_count++;
					end
				end
				rx_count++;
				if (rx_count % 200 == 100)
					pause_len = 60;
				else
					pause_len = calm ? 0 : $urandom_range(0, 4);
				if (pause_len > 0) begin
					m_tready  <= 1'b0;
					hold_left <= pause_len;
				end
			end else if (hold_left > 1) begin
				hold_left <= hold_left - 1;
			end else begin
				hold_left <= 0;
				m_tready  <= 1'b1;
			end
		end
	end

	initial begin
		cfg_gain    = GAIN_RST;
		cfg_timeout = TIMEOUT_RST;
		cfg_thresh  = THR_RST;
		still_run   = 0;
		for (int i = 0; i < 3; i++)
			axis_offset[i] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset defaults: extremes and the motion threshold edge
		send(0, 0, 0);
		send(RATE_HI, RATE_HI, RATE_HI);
		send(RATE_LO, RATE_LO, RATE_LO);
		send(RATE_HI, RATE_LO, 0);
		send(196608, -196608, 0);
		send(196609, 0, 0);
		send(0, 0, -196609);
		send(1, -1, 'h5555555);
		drain();

		// zero timeout, full gain: offsets saturate, then get pulled back
		setup(GAIN_MASK, 0, THR_MASK);
		write_reg(REG_SPARE, 0);
		send(RATE_HI, RATE_LO + 1, 0);
		send(RATE_HI, RATE_LO + 1, 0);
		send(RATE_LO, RATE_HI, 0);
		send(1, -1, 0);
		send(0, 0, 0);
		send(0, 0, 0);
		drain();

		// count up to a short timeout, then track
		setup(GAIN_RST, 4, THR_RST);
		for (int i = 0; i < 8; i++)
			send(near_offset(0), near_offset(1), near_offset(2));
		drain();

		// lower the timeout below the current count
		write_reg(REG_STILL_TIMEOUT, 1);
		setting_count++;
		for (int i = 0; i < 3; i++)
			send(near_offset(0), near_offset(1), near_offset(2));
		drain();

		setup($urandom, $urandom_range(0, 20) | (longint'($urandom_range(0, 127)) << 20),
			$urandom_range(0, 1 << 20));
		run_random(150);

		setup(0, CNT_MASK, 0);
		run_random(60);

		calm = 1'b1;
		setup(GAIN_MASK, 1, $urandom_range(0, 1 << 18));
		run_random(120);
		calm = 1'b0;

		setup($urandom, $urandom_range(0, 10), $urandom);
		run_random(120);

		setup(GAIN_RST, TIMEOUT_RST, THR_RST);
		run_random(120);

		repeat (10) @(posedge clk);
		if (corrected_q.size() != 0) begin
			$error("results left over: expected 0, got %0d", corrected_q.size());
			err_count++;
		end
		$display("Checked %0d corrected samples over %0d register settings,", rx_count,
			setting_count);
		$display("with %0d offset updates and long output stalls.", update_count);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/got_pkg.sv
rtl/got_axis.sv
rtl/gyro_offset_tracker_unit.sv
tb/tb_gyro_offset_tracker_unit.sv
